// ===== hdl/sbbr_pkg.sv =====
// shared types, constants and helper functions for the stuck-bit byte repair block
`default_nettype none

package sbbr_pkg;

  localparam int unsigned SYMBOL_BITS  = 8;
  localparam int unsigned COUNTER_BITS = 32;
  localparam int unsigned SET_DEPTH    = 1 << SYMBOL_BITS;
  localparam int unsigned COUNT_W      = $clog2(SYMBOL_BITS + 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SCAN   = 2'd1,
    CMD_REPAIR = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CLS_MATCHED   = 3'd0,
    CLS_CORRECTED = 3'd1,
    CLS_AMBIGUOUS = 3'd2,
    CLS_UNMATCHED = 3'd3,
    CLS_NONE      = 3'd4
  } class_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [SYMBOL_BITS-1:0] byte_in;
  } in_beat_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0]  byte_out;
    logic [2:0]              repair_class;
    logic [SYMBOL_BITS-1:0]  stuck_mask;
    logic [COUNT_W-1:0]      stuck_count;
    logic [COUNTER_BITS-1:0] corrected_total;
    logic [COUNTER_BITS-1:0] matched_total;
    logic [COUNTER_BITS-1:0] unmatched_total;
    logic [COUNTER_BITS-1:0] ambiguous_total;
  } out_beat_t;

  // one finished lookup handed from the sequencer to the tracker
  typedef struct packed {
    logic                   valid;
    logic [1:0]             cmd;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   as_is;
    logic                   as_flip;
  } upd_t;

  function automatic logic [COUNT_W-1:0] popcount(logic [SYMBOL_BITS-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < SYMBOL_BITS; k++) begin
      n = n + COUNT_W'(v[k]);
    end
    return n;
  endfunction

  function automatic logic [COUNTER_BITS-1:0] sat_inc(logic [COUNTER_BITS-1:0] c);
    return (&c) ? c : c + COUNTER_BITS'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sbbr_set_mem.sv =====
// allowed-value set: one write port, two registered read ports
`default_nettype none

module sbbr_set_mem (
  input  wire logic                               clk_i,
  input  wire logic                               wr_en_i,
  input  wire logic [sbbr_pkg::SYMBOL_BITS-1:0]   wr_addr_i,
  input  wire logic                               wr_data_i,
  input  wire logic                               rd_en_i,
  input  wire logic [sbbr_pkg::SYMBOL_BITS-1:0]   rd_addr_a_i,
  input  wire logic [sbbr_pkg::SYMBOL_BITS-1:0]   rd_addr_b_i,
  output logic                                    rd_data_a_o,
  output logic                                    rd_data_b_o
);

  logic mem_q [sbbr_pkg::SET_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sbbr_track.sv =====
// scan mask, reference byte, repair classification and saturating counters
`default_nettype none

module sbbr_track (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sbbr_pkg::upd_t                    upd_i,
  output logic [sbbr_pkg::SYMBOL_BITS-1:0]       mask_o,
  output sbbr_pkg::out_beat_t                    res_o
);

  logic [sbbr_pkg::SYMBOL_BITS-1:0]  ref_q, ref_d;
  logic [sbbr_pkg::SYMBOL_BITS-1:0]  cmask_q, cmask_d;
  logic                              seen_q, seen_d;
  logic [sbbr_pkg::COUNTER_BITS-1:0] corr_q, corr_d;
  logic [sbbr_pkg::COUNTER_BITS-1:0] match_q, match_d;
  logic [sbbr_pkg::COUNTER_BITS-1:0] unm_q, unm_d;
  logic [sbbr_pkg::COUNTER_BITS-1:0] amb_q, amb_d;

  logic [sbbr_pkg::SYMBOL_BITS-1:0]  mask_new;
  logic [sbbr_pkg::SYMBOL_BITS-1:0]  byte_out;
  sbbr_pkg::class_e                  cls;

  // mask as seen by a repair: nothing is stuck before the first scan
  assign mask_o = seen_q ? cmask_q : '0;

  always_comb begin
    ref_d    = ref_q;
    cmask_d  = cmask_q;
    seen_d   = seen_q;
    corr_d   = corr_q;
    match_d  = match_q;
    unm_d    = unm_q;
    amb_d    = amb_q;
    byte_out = upd_i.sym;
    cls      = sbbr_pkg::CLS_NONE;
    unique case (sbbr_pkg::cmd_e'(upd_i.cmd))
      sbbr_pkg::CMD_LOAD: begin
      end
      sbbr_pkg::CMD_SCAN: begin
        if (!seen_q) begin
          ref_d  = upd_i.sym;
          seen_d = 1'b1;
        end else begin
          cmask_d = cmask_q & ~(upd_i.sym ^ ref_q);
        end
      end
      sbbr_pkg::CMD_REPAIR: begin
        if ($onehot(mask_o)) begin
          if (upd_i.as_is) begin
            match_d = sbbr_pkg::sat_inc(match_q);
          end
          priority if (upd_i.as_is && upd_i.as_flip) begin
            cls   = sbbr_pkg::CLS_AMBIGUOUS;
            amb_d = sbbr_pkg::sat_inc(amb_q);
          end else if (upd_i.as_is) begin
            cls = sbbr_pkg::CLS_MATCHED;
          end else if (upd_i.as_flip) begin
            cls      = sbbr_pkg::CLS_CORRECTED;
            byte_out = upd_i.sym ^ mask_o;
            corr_d   = sbbr_pkg::sat_inc(corr_q);
          end else begin
            cls   = sbbr_pkg::CLS_UNMATCHED;
            unm_d = sbbr_pkg::sat_inc(unm_q);
          end
        end
      end
      sbbr_pkg::CMD_CLEAR: begin
        ref_d   = '0;
        cmask_d = '1;
        seen_d  = 1'b0;
        corr_d  = '0;
        match_d = '0;
        unm_d   = '0;
        amb_d   = '0;
      end
      default: begin
      end
    endcase
  end

  // result reflects the state after this beat
  assign mask_new = seen_d ? cmask_d : '0;

  always_comb begin
    res_o.byte_out        = byte_out;
    res_o.repair_class    = cls;
    res_o.stuck_mask      = mask_new;
    res_o.stuck_count     = sbbr_pkg::popcount(mask_new);
    res_o.corrected_total = corr_d;
    res_o.matched_total   = match_d;
    res_o.unmatched_total = unm_d;
    res_o.ambiguous_total = amb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= '0;
      cmask_q <= '1;
      seen_q  <= 1'b0;
      corr_q  <= '0;
      match_q <= '0;
      unm_q   <= '0;
      amb_q   <= '0;
    end else if (upd_i.valid) begin
      ref_q   <= ref_d;
      cmask_q <= cmask_d;
      seen_q  <= seen_d;
      corr_q  <= corr_d;
      match_q <= match_d;
      unm_q   <= unm_d;
      amb_q   <= amb_d;
    end
  end

`ifndef SYNTHESIS
  a_seen_stable_until_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q && !(upd_i.valid && upd_i.cmd == sbbr_pkg::CMD_CLEAR) |=> seen_q)
    else $error("seen flag dropped without a clear");
  a_mask_only_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(upd_i.valid && upd_i.cmd == sbbr_pkg::CMD_CLEAR) |=> (cmask_q & ~$past(cmask_q)) == '0)
    else $error("constant mask gained a bit without a clear");
  a_corrected_single_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.valid && res_o.repair_class == sbbr_pkg::CLS_CORRECTED
      |-> $onehot(res_o.byte_out ^ upd_i.sym))
    else $error("corrected byte differs in other than one bit");
`endif

endmodule

`default_nettype wire

// ===== hdl/stuck_bit_byte_repair.sv =====
// top level: beat sequencer, set memory, tracker and output register
`default_nettype none

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_beat_i  (cmd, byte_in)
//  out     | source    | out_valid_o/ out_stall_i| out_beat_o (byte, class, totals)
//
//  each beat passes ST_IDLE and ST_LOOK: the accept issues both set reads (byte and
//  byte with the stuck bit flipped), and ST_LOOK classifies and writes back
//  after reset, and after every clear command, a sweep zeroes the 256-entry set
//  memory one entry a cycle with in_stall_o high
//  a new beat is taken while a result still waits in the output register; the
//  lookup then holds until that register is free

module stuck_bit_byte_repair (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sbbr_pkg::in_beat_t   in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sbbr_pkg::out_beat_t       out_beat_o
);

  sbbr_pkg::state_e                 state_q, state_d;
  logic [sbbr_pkg::SYMBOL_BITS-1:0] clr_ptr_q, clr_ptr_d;
  sbbr_pkg::in_beat_t               beat_q;
  sbbr_pkg::out_beat_t              out_q;
  logic                             out_valid_q, out_valid_d;

  logic                             accept;
  logic                             finish;
  logic                             rd_en;
  logic                             wr_en;
  logic [sbbr_pkg::SYMBOL_BITS-1:0] wr_addr;
  logic                             wr_data;
  logic                             as_is;
  logic                             as_flip;
  logic [sbbr_pkg::SYMBOL_BITS-1:0] mask;
  sbbr_pkg::upd_t                   upd;
  sbbr_pkg::out_beat_t              res;

  assign accept = in_valid_i && !in_stall_o;
  // lookup completes once the output register can take the result
  assign finish = (state_q == sbbr_pkg::ST_LOOK) && !(out_valid_q && out_stall_i);

  // next state
  always_comb begin
    state_d   = state_q;
    clr_ptr_d = clr_ptr_q;
    unique case (state_q)
      sbbr_pkg::ST_CLEAR: begin
        clr_ptr_d = clr_ptr_q + 1'b1;
        if (&clr_ptr_q) begin
          state_d = sbbr_pkg::ST_IDLE;
        end
      end
      sbbr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sbbr_pkg::ST_LOOK;
        end
      end
      sbbr_pkg::ST_LOOK: begin
        if (finish) begin
          if (beat_q.cmd == sbbr_pkg::CMD_CLEAR) begin
            state_d   = sbbr_pkg::ST_CLEAR;
            clr_ptr_d = '0;
          end else begin
            state_d = sbbr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sbbr_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = beat_q.byte_in;
    wr_data    = 1'b1;
    unique case (state_q)
      sbbr_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ptr_q;
        wr_data = 1'b0;
      end
      sbbr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
      end
      sbbr_pkg::ST_LOOK: begin
        // load writes back at the end of its lookup
        wr_en = finish && (beat_q.cmd == sbbr_pkg::CMD_LOAD);
      end
      default: begin
      end
    endcase
  end

  // read both the byte and its flipped form; mask is stable until write-back
  sbbr_set_mem u_set_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (in_beat_i.byte_in),
    .rd_addr_b_i (in_beat_i.byte_in ^ mask),
    .rd_data_a_o (as_is),
    .rd_data_b_o (as_flip)
  );

  always_comb begin
    upd.valid   = finish;
    upd.cmd     = beat_q.cmd;
    upd.sym     = beat_q.byte_in;
    upd.as_is   = as_is;
    upd.as_flip = as_flip;
  end

  sbbr_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .mask_o (mask),
    .res_o  (res)
  );

  // output register: filled on finish, emptied when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbbr_pkg::ST_CLEAR;
      clr_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= in_beat_i;
    end
    if (finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTHESIS
  a_accept_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == sbbr_pkg::ST_LOOK)
    else $error("accepted beat did not enter lookup");
  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == sbbr_pkg::ST_LOOK)
    else $error("result appeared without a lookup");
  a_sweep_runs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sbbr_pkg::ST_CLEAR && !(&clr_ptr_q) |=> state_q == sbbr_pkg::ST_CLEAR)
    else $error("clearing sweep ended early");
  a_class_needs_single_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.repair_class != sbbr_pkg::CLS_NONE
      |-> out_q.stuck_count == sbbr_pkg::COUNT_W'(1))
    else $error("repair class given without exactly one stuck bit");
`endif

endmodule

`default_nettype wire

// ===== dv/stuck_bit_byte_repair_checker.sv =====
// checker: predicts every repair result from the input beats and compares the output beats
`timescale 1ns / 1ps

module stuck_bit_byte_repair_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire sbbr_pkg::in_beat_t  in_beat_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire sbbr_pkg::out_beat_t out_beat_i,
  output int                       mismatch_count_o,
  output int                       pending_o,
  output int                       checked_o,
  output logic [4:0]               classes_seen_o
);
  import sbbr_pkg::*;

  localparam int MAX_REPORTS = 10;

  // predicted block state
  logic                    allowed_vals [SET_DEPTH];
  logic [SYMBOL_BITS-1:0]  first_sym;
  logic [SYMBOL_BITS-1:0]  steady_bits;
  logic                    scanned;
  logic [COUNTER_BITS-1:0] n_corrected;
  logic [COUNTER_BITS-1:0] n_matched;
  logic [COUNTER_BITS-1:0] n_unmatched;
  logic [COUNTER_BITS-1:0] n_ambiguous;

  out_beat_t expected_beats [$];
  out_beat_t want;

  function automatic logic [COUNTER_BITS-1:0] bump(logic [COUNTER_BITS-1:0] c);
    if (c != {COUNTER_BITS{1'b1}}) begin
      c = c + 1'b1;
    end
    return c;
  endfunction

  function automatic void wipe_model();
    for (int i = 0; i < SET_DEPTH; i++) begin
      allowed_vals[i] = 1'b0;
    end
    first_sym   = '0;
    steady_bits = '1;
    scanned     = 1'b0;
    n_corrected = '0;
    n_matched   = '0;
    n_unmatched = '0;
    n_ambiguous = '0;
  endfunction

  function automatic out_beat_t repair_step(in_beat_t b);
    out_beat_t              r;
    logic [SYMBOL_BITS-1:0] live;
    logic [SYMBOL_BITS-1:0] flipped;
    logic                   as_is;
    logic                   as_flip;
    r              = '0;
    r.byte_out     = b.byte_in;
    r.repair_class = CLS_NONE;
    case (b.cmd)
      CMD_LOAD: begin
        allowed_vals[b.byte_in] = 1'b1;
      end
      CMD_SCAN: begin
        if (!scanned) begin
          first_sym = b.byte_in;
          scanned   = 1'b1;
        end else begin
          steady_bits &= ~(b.byte_in ^ first_sym);
        end
      end
      CMD_REPAIR: begin
        live = scanned ? steady_bits : '0;
        if ($countones(live) == 1) begin
          flipped = b.byte_in ^ live;
          as_is   = allowed_vals[b.byte_in];
          as_flip = allowed_vals[flipped];
          if (as_is) begin
            n_matched = bump(n_matched);
          end
          if (as_is && as_flip) begin
            r.repair_class = CLS_AMBIGUOUS;
            n_ambiguous    = bump(n_ambiguous);
          end else if (as_is) begin
            r.repair_class = CLS_MATCHED;
          end else if (as_flip) begin
            r.repair_class = CLS_CORRECTED;
            r.byte_out     = flipped;
            n_corrected    = bump(n_corrected);
          end else begin
            r.repair_class = CLS_UNMATCHED;
            n_unmatched    = bump(n_unmatched);
          end
        end
      end
      default: begin
        wipe_model();
      end
    endcase
    live              = scanned ? steady_bits : '0;
    r.stuck_mask      = live;
    r.stuck_count     = COUNT_W'($countones(live));
    r.corrected_total = n_corrected;
    r.matched_total   = n_matched;
    r.unmatched_total = n_unmatched;
    r.ambiguous_total = n_ambiguous;
    return r;
  endfunction

  function automatic string beat_text(out_beat_t b);
    return $sformatf("byte %h class %0d mask %h count %0d corr %0d match %0d unm %0d amb %0d",
                     b.byte_out, b.repair_class, b.stuck_mask, b.stuck_count,
                     b.corrected_total, b.matched_total, b.unmatched_total,
                     b.ambiguous_total);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_model();
      expected_beats.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
      classes_seen_o   = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_beats.push_back(repair_step(in_beat_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MAX_REPORTS) begin
            $display("result beat with nothing expected: %s", beat_text(out_beat_i));
          end
        end else begin
          want = expected_beats.pop_front();
          checked_o++;
          classes_seen_o[want.repair_class] = 1'b1;
          if (out_beat_i.byte_out        !== want.byte_out        ||
              out_beat_i.repair_class    !== want.repair_class    ||
              out_beat_i.stuck_mask      !== want.stuck_mask      ||
              out_beat_i.stuck_count     !== want.stuck_count     ||
              out_beat_i.corrected_total !== want.corrected_total ||
              out_beat_i.matched_total   !== want.matched_total   ||
              out_beat_i.unmatched_total !== want.unmatched_total ||
              out_beat_i.ambiguous_total !== want.ambiguous_total) begin
            mismatch_count_o++;
            if (mismatch_count_o <= MAX_REPORTS) begin
              $display("result %0d mismatch, expected: %s", checked_o, beat_text(want));
              $display("result %0d mismatch, actual:   %s", checked_o, beat_text(out_beat_i));
            end
          end
        end
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

// ===== dv/stuck_bit_byte_repair_tb.sv =====
// testbench top: clock, reset, beat stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps

module stuck_bit_byte_repair_tb;
  import sbbr_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int PHASE_BEATS  = 530;
  // longest quiet stretch in a good run is the set sweep after a
  // clear plus a run of receiver stalls; this leaves a wide margin
  localparam int QUIET_LIMIT  = 4000;
  // a beat passes the lookup and the output register, so this drains everything
  localparam int DRAIN_CYCLES = 20;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // idle and stall rates in percent, changed per phase
  int send_idle_pct  = 8;
  int recv_stall_pct = 70;

  int beats_sent  = 0;
  int sessions    = 0;
  int quiet_cycles = 0;
  int mismatches;
  int pending;
  int checked;
  logic [4:0] classes_seen;

  stuck_bit_byte_repair uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  stuck_bit_byte_repair_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_beat_i        (in_beat),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_beat_i       (out_beat),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .classes_seen_o   (classes_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // receiver side: stall drawn fresh every cycle
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog: cycles with no beat accepted on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // one input beat; entered and left right after a rising edge
  task automatic send_beat(input cmd_e cmd, input logic [SYMBOL_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= {cmd, value};
    // stall is settled by mid-cycle; the next edge takes the beat if it is low
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    beats_sent++;
  endtask

  // clear, load a set, usually scan with a chosen stuck pattern, then mostly repair
  task automatic run_session();
    logic [SYMBOL_BITS-1:0] flip_bit;
    logic [SYMBOL_BITS-1:0] keep;
    logic [SYMBOL_BITS-1:0] base;
    logic [SYMBOL_BITS-1:0] v;
    logic [SYMBOL_BITS-1:0] pool [$];
    int                     mode;
    int                     pick;
    mode     = $urandom_range(9);
    flip_bit = 8'd1 << $urandom_range(SYMBOL_BITS - 1);
    base     = SYMBOL_BITS'($urandom);
    // mostly one stuck bit, sometimes none, sometimes several
    if (mode == 0) begin
      keep = '0;
    end else if (mode == 1) begin
      keep = SYMBOL_BITS'($urandom);
      while ($countones(keep) < 2) keep = SYMBOL_BITS'($urandom);
    end else begin
      keep = flip_bit;
    end

    send_beat(CMD_CLEAR, SYMBOL_BITS'($urandom));

    repeat ($urandom_range(1, 48)) begin
      v = SYMBOL_BITS'($urandom);
      pool.push_back(v);
      send_beat(CMD_LOAD, v);
      // partner value so that ambiguous lookups happen
      if ($urandom_range(3) == 0) begin
        pool.push_back(v ^ flip_bit);
        send_beat(CMD_LOAD, v ^ flip_bit);
      end
    end

    // base and its free bits inverted pins down the mask; extra scans keep it
    if (mode != 0 || $urandom_range(1) == 1) begin
      send_beat(CMD_SCAN, base);
      send_beat(CMD_SCAN, base ^ ~keep);
      repeat ($urandom_range(0, 8)) begin
        v = SYMBOL_BITS'($urandom);
        send_beat(CMD_SCAN, (base & keep) | (v & ~keep));
      end
    end

    repeat ($urandom_range(8, 40)) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        // noise: any command, any byte, may break the mask
        send_beat(cmd_e'(2'($urandom_range(3))), SYMBOL_BITS'($urandom));
      end else if (pick < 8) begin
        // scan interleaved with repair, same stuck pattern
        v = SYMBOL_BITS'($urandom);
        send_beat(CMD_SCAN, (base & keep) | (v & ~keep));
      end else begin
        v = pool[$urandom_range(pool.size() - 1)];
        case ($urandom_range(2))
          0: v = v;
          1: v = v ^ flip_bit;
          default: v = SYMBOL_BITS'($urandom);
        endcase
        send_beat(CMD_REPAIR, v);
      end
    end
    sessions++;
  endtask

  initial begin
    int target;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: nothing scanned yet, so no stuck bit
    send_beat(CMD_REPAIR, 8'h00);
    send_beat(CMD_LOAD, 8'hFF);
    send_beat(CMD_LOAD, 8'h00);
    send_beat(CMD_LOAD, 8'h01);
    // a single scan leaves every bit stuck
    send_beat(CMD_SCAN, 8'h00);
    send_beat(CMD_REPAIR, 8'hFF);
    // now only bit 0 stays constant
    send_beat(CMD_SCAN, 8'hFE);
    send_beat(CMD_REPAIR, 8'h00);   // found both ways
    send_beat(CMD_REPAIR, 8'hFF);   // found as it is
    send_beat(CMD_REPAIR, 8'hFE);   // found only flipped
    send_beat(CMD_REPAIR, 8'h80);   // found neither way
    // bit 0 toggles too: nothing stuck
    send_beat(CMD_SCAN, 8'h01);
    send_beat(CMD_REPAIR, 8'h55);
    send_beat(CMD_CLEAR, 8'hAA);
    send_beat(CMD_REPAIR, 8'h01);
    // fresh pass after clear with bit 7 stuck low
    send_beat(CMD_SCAN, 8'h00);
    send_beat(CMD_SCAN, 8'h7F);
    send_beat(CMD_LOAD, 8'h80);
    send_beat(CMD_REPAIR, 8'h00);
    send_beat(CMD_SCAN, 8'h3F);
    send_beat(CMD_REPAIR, 8'h80);

    // random sessions under three idle/stall mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 8;
          recv_stall_pct = 70;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) run_session();
    end
    in_valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d input beats in %0d clear/load/scan/repair sessions",
             beats_sent, sessions);
    $display("%0d results compared, repair classes seen (bit per class) %b",
             checked, classes_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
